[rtl/sdq_pkg.sv]
// ---------------------------------------------------------------------------
// sdq_pkg
// shared widths and constants of the stereo dither quantizer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdq_pkg;

  localparam int unsigned SAMPLE_W          = 26;
  localparam int unsigned PCM_W             = 16;
  localparam int unsigned SEED_W            = 31;
  localparam int unsigned FRACTION_BITS_DEF = 8;

  // slave tdata: left, right, zero pad up to whole bytes
  localparam int unsigned S_TDATA_W = ((2 * SAMPLE_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = 2 * PCM_W;

  localparam logic [SEED_W-1:0] SEED_RESET = 31'h16BA2118;
  localparam logic [SEED_W-1:0] LCG_MUL    = 31'd1103515245;
  localparam logic [SEED_W-1:0] LCG_ADD    = 31'd12345;

  // rounded value before clamping: sample plus sign and carry headroom
  localparam int unsigned QNT_W = SAMPLE_W + 2;

  localparam logic signed [QNT_W-1:0] PCM_MIN = -28'sd32768;
  localparam logic signed [QNT_W-1:0] PCM_MAX = 28'sd32767;

endpackage

[rtl/sdq_quant.sv]
// ---------------------------------------------------------------------------
// sdq_quant
// adds dither, rounds to nearest with ties to even, clamps to int16
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdq_quant #(
  parameter int unsigned FRACTION_BITS = sdq_pkg::FRACTION_BITS_DEF
) (
  input  logic signed [sdq_pkg::SAMPLE_W-1:0] sample_i,
  input  logic        [FRACTION_BITS-1:0]     dither_i,
  output logic        [sdq_pkg::PCM_W-1:0]    pcm_o
);

  localparam int unsigned SumW = sdq_pkg::SAMPLE_W + 1;
  localparam int unsigned QntW = sdq_pkg::QNT_W;
  localparam logic [FRACTION_BITS-1:0] Half = FRACTION_BITS'(1) << (FRACTION_BITS - 1);

  logic signed [SumW-1:0]            sum;
  logic        [FRACTION_BITS-1:0]   frac;
  logic signed [SumW-1:0]            whole;
  logic                              round_up;
  logic signed [QntW-1:0]            rounded;

  always_comb begin
    sum      = SumW'(sample_i) + $signed({1'b0, (SumW-1)'(dither_i)});
    frac     = sum[FRACTION_BITS-1:0];
    whole    = sum >>> FRACTION_BITS;
    round_up = (frac > Half) || ((frac == Half) && whole[0]);
    rounded  = QntW'(whole) + $signed({{(QntW-1){1'b0}}, round_up});
    if (rounded < sdq_pkg::PCM_MIN) begin
      pcm_o = sdq_pkg::PCM_MIN[sdq_pkg::PCM_W-1:0];
    end else if (rounded > sdq_pkg::PCM_MAX) begin
      pcm_o = sdq_pkg::PCM_MAX[sdq_pkg::PCM_W-1:0];
    end else begin
      pcm_o = rounded[sdq_pkg::PCM_W-1:0];
    end
  end

endmodule

[rtl/stereo_dither_quantizer_core.sv]
// ---------------------------------------------------------------------------
// stereo_dither_quantizer_core
// stereo frame to packed int16 pcm word, optional lcg rectangular dither
// ---------------------------------------------------------------------------
//  channel  | signals                          | word
//  ---------+----------------------------------+---------------------------------
//  s_axis   | tvalid tready tdata[55:0] tlast  | left[25:0] right[51:26], eob
//  m_axis   | tvalid tready tdata[31:0] tlast  | left pcm[15:0] right pcm[31:16]
//  cfg      | cfg_we_i cfg_wdata_i             | dither_on
//
//  with dither on a frame goes through accept, two lcg steps on the one
//  31x31 multiply-add and two passes through the shared quantizer, the last
//  of which registers the word; with dither off the lcg steps are skipped.
//  s_axis_tready is high only idle.
//  a finished word sits in the output register while the next frame is taken;
//  the last quantizer pass waits while that register is full and m_axis_tready is low.
//  reset: seed 0x16BA2118, dither off, no word pending.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_dither_quantizer_core #(
  parameter int unsigned FRACTION_BITS = sdq_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [sdq_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // left_sample, right_sample, pad
  input  logic                            s_axis_tlast,   // end_of_block
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [sdq_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // left pcm, right pcm
  output logic                            m_axis_tlast    // block_done
);

  localparam int unsigned SW = sdq_pkg::SAMPLE_W;
  localparam int unsigned PW = sdq_pkg::PCM_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LCG_R,
    ST_LCG_L,
    ST_QNT_R,
    ST_QNT_L
  } state_e;

  state_e                          state_q;
  logic                            dither_on_q;
  logic [sdq_pkg::SEED_W-1:0]      seed_q;
  logic [sdq_pkg::SEED_W-1:0]      seed_d;
  logic [FRACTION_BITS-1:0]        dith_r_q;
  logic [FRACTION_BITS-1:0]        dith_l_q;
  logic signed [SW-1:0]            left_q;
  logic signed [SW-1:0]            right_q;
  logic                            last_q;
  logic [PW-1:0]                   pcm_r_q;
  logic                            out_valid_q;
  logic [sdq_pkg::M_TDATA_W-1:0]   out_data_q;
  logic                            out_last_q;

  logic signed [SW-1:0]            qnt_sample;
  logic [FRACTION_BITS-1:0]        qnt_dither;
  logic [PW-1:0]                   qnt_pcm;
  logic                            out_free;

  // shared multiply-add, keeps the low 31 bits only
  assign seed_d = (seed_q * sdq_pkg::LCG_MUL) + sdq_pkg::LCG_ADD;

  assign qnt_sample = (state_q == ST_QNT_L) ? left_q : right_q;
  assign qnt_dither = (state_q == ST_QNT_L) ? dith_l_q : dith_r_q;

  sdq_quant #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_quant (
    .sample_i (qnt_sample),
    .dither_i (qnt_dither),
    .pcm_o    (qnt_pcm)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dither_on_q <= 1'b0;
      seed_q      <= sdq_pkg::SEED_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dither_on_q <= cfg_wdata_i;
      end
      // the last pass reloads the output register itself
      if (out_valid_q && m_axis_tready && (state_q != ST_QNT_L)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            left_q   <= s_axis_tdata[SW-1:0];
            right_q  <= s_axis_tdata[2*SW-1:SW];
            last_q   <= s_axis_tlast;
            dith_r_q <= '0;
            dith_l_q <= '0;
            state_q  <= dither_on_q ? ST_LCG_R : ST_QNT_R;
          end
        end
        ST_LCG_R: begin
          seed_q   <= seed_d;
          dith_r_q <= seed_d[sdq_pkg::SEED_W-1 -: FRACTION_BITS];
          state_q  <= ST_LCG_L;
        end
        ST_LCG_L: begin
          seed_q   <= seed_d;
          dith_l_q <= seed_d[sdq_pkg::SEED_W-1 -: FRACTION_BITS];
          state_q  <= ST_QNT_R;
        end
        ST_QNT_R: begin
          pcm_r_q <= qnt_pcm;
          state_q <= ST_QNT_L;
        end
        ST_QNT_L: begin
          // hold here until the output register can take the word
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {pcm_r_q, qnt_pcm};
            out_last_q  <= last_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/stereo_dither_quantizer_checker.sv]
// ---------------------------------------------------------------------------
// stereo_dither_quantizer_checker
// watches the frame and pcm channels, predicts every pcm word and compares
// ---------------------------------------------------------------------------
// keeps its own copy of the lcg seed and the dither switch, works out the
// rounded and clamped pcm pair for each accepted frame and queues it; each
// word leaving the block is checked field by field against the oldest entry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_dither_quantizer_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [sdq_pkg::S_TDATA_W-1:0] s_axis_tdata,   // left_sample, right_sample, pad
  input  logic                          s_axis_tlast,   // end_of_block
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [sdq_pkg::M_TDATA_W-1:0] m_axis_tdata,   // left pcm, right pcm
  input  logic                          m_axis_tlast,   // block_done
  output int unsigned                   mismatch_count_o,
  output int unsigned                   words_pending_o
);

  localparam int unsigned FB  = sdq_pkg::FRACTION_BITS_DEF;
  localparam int unsigned PW  = sdq_pkg::PCM_W;
  localparam int unsigned SW  = sdq_pkg::SAMPLE_W;
  localparam int unsigned SDW = sdq_pkg::SEED_W;

  typedef struct packed {
    logic [PW-1:0] right_pcm;
    logic [PW-1:0] left_pcm;
    logic          block_done;
  } pcm_word_t;

  pcm_word_t      pcm_words_due[$];
  pcm_word_t      predicted;
  pcm_word_t      observed;
  logic [SDW-1:0] noise_seed;
  logic [SDW-1:0] seed_walk;
  logic           dither_en;
  logic [FB-1:0]  dither_r;
  logic [FB-1:0]  dither_l;
  int unsigned    mismatches;

  // seed * mul + add, wraps at 31 bits by the width of the expression
  function automatic logic [SDW-1:0] lcg_advance(input logic [SDW-1:0] seed);
    logic [SDW-1:0] nxt;
    nxt = seed * sdq_pkg::LCG_MUL + sdq_pkg::LCG_ADD;
    return nxt;
  endfunction

  // add dither fraction, round half to even, clamp to int16
  function automatic logic [PW-1:0] round_to_pcm(input logic signed [SW-1:0] smp,
                                                 input logic [FB-1:0] dither);
    longint v;
    longint frac;
    longint whole;
    longint half;
    v     = longint'(smp) + longint'(dither);
    half  = longint'(1) << (FB - 1);
    frac  = v & ((longint'(1) << FB) - 1);
    whole = v >>> FB;
    if (frac > half || (frac == half && whole[0])) begin
      whole = whole + 1;
    end
    if (whole < sdq_pkg::PCM_MIN) begin
      whole = sdq_pkg::PCM_MIN;
    end else if (whole > sdq_pkg::PCM_MAX) begin
      whole = sdq_pkg::PCM_MAX;
    end
    return whole[PW-1:0];
  endfunction

  function automatic int field_differs(input string field, input logic [PW-1:0] want,
                                       input logic [PW-1:0] seen);
    if (want !== seen) begin
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, field, want, seen);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcm_words_due.delete();
      noise_seed       = sdq_pkg::SEED_RESET;
      dither_en        = 1'b0;
      mismatches       = 0;
      mismatch_count_o <= 0;
      words_pending_o  <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        seed_walk = noise_seed;
        dither_r  = '0;
        dither_l  = '0;
        // right channel draws first
        if (dither_en) begin
          seed_walk = lcg_advance(seed_walk);
          dither_r  = seed_walk[SDW-1 -: FB];
          seed_walk = lcg_advance(seed_walk);
          dither_l  = seed_walk[SDW-1 -: FB];
        end
        noise_seed           = seed_walk;
        predicted.right_pcm  = round_to_pcm(s_axis_tdata[2*SW-1:SW], dither_r);
        predicted.left_pcm   = round_to_pcm(s_axis_tdata[SW-1:0], dither_l);
        predicted.block_done = s_axis_tlast;
        pcm_words_due.push_back(predicted);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        observed = {m_axis_tdata[2*PW-1:PW], m_axis_tdata[PW-1:0], m_axis_tlast};
        if (pcm_words_due.size() == 0) begin
          $display("%0t ns: word with none expected, expected none actual %h", $time,
                   observed);
          mismatches = mismatches + 1;
        end else begin
          predicted  = pcm_words_due.pop_front();
          mismatches = mismatches
                     + field_differs("right pcm", predicted.right_pcm, observed.right_pcm)
                     + field_differs("left pcm", predicted.left_pcm, observed.left_pcm)
                     + field_differs("block done", PW'(predicted.block_done),
                                     PW'(observed.block_done));
        end
      end
      if (cfg_we_i) begin
        dither_en = cfg_wdata_i;
      end
      mismatch_count_o <= mismatches;
      words_pending_o  <= unsigned'(pcm_words_due.size());
    end
  end

endmodule

[tb/stereo_dither_quantizer_core_tb.sv]
// ---------------------------------------------------------------------------
// stereo_dither_quantizer_core_tb
// stimulus and verdict for the stereo dither quantizer
// ---------------------------------------------------------------------------
// corner samples with dither off and on, then random frames in phases that
// toggle dither and change how often each side idles, with one long hold-off
// on the pcm side; prediction and checking live in the checker module.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_dither_quantizer_core_tb;

  localparam int unsigned SW              = sdq_pkg::SAMPLE_W;
  localparam int unsigned STW             = sdq_pkg::S_TDATA_W;
  localparam int unsigned MTW             = sdq_pkg::M_TDATA_W;
  localparam int unsigned CYCLE_LIMIT     = 500000;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned SETTLE_CYCLES   = 10;
  localparam int unsigned FRAMES_PER_PASS = 240;
  localparam int unsigned NUM_CORNERS     = 12;

  logic           clk_i       = 1'b0;
  logic           rst_n       = 1'b0;
  logic           cfg_we      = 1'b0;
  logic           cfg_wdata   = 1'b0;
  logic           s_valid     = 1'b0;
  logic           s_ready;
  logic [STW-1:0] s_data      = '0;
  logic           s_last      = 1'b0;
  logic           m_valid;
  logic           m_ready     = 1'b0;
  logic [MTW-1:0] m_data;
  logic           m_last;

  int unsigned mismatch_count;
  int unsigned words_pending;
  int unsigned send_idle_pct  = 36;
  int unsigned recv_idle_pct  = 73;
  int unsigned holds_asked    = 0;
  int unsigned holds_served   = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;

  // in 1/256 units: range ends, ties, clamp edges
  logic signed [SW-1:0] corner_samples [NUM_CORNERS] = '{
    SW'(33554431), SW'(-33554432), SW'(0), SW'(128), SW'(384), SW'(640), SW'(-384),
    SW'(8388480), SW'(8388224), SW'(-8388736), SW'(-8388737), 26'h2AAAAAA
  };

  always #6 clk_i = ~clk_i;

  stereo_dither_quantizer_core #(
    .FRACTION_BITS (sdq_pkg::FRACTION_BITS_DEF)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last)
  );

  stereo_dither_quantizer_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .s_axis_tvalid    (s_valid),
    .s_axis_tready    (s_ready),
    .s_axis_tdata     (s_data),
    .s_axis_tlast     (s_last),
    .m_axis_tvalid    (m_valid),
    .m_axis_tready    (m_ready),
    .m_axis_tdata     (m_data),
    .m_axis_tlast     (m_last),
    .mismatch_count_o (mismatch_count),
    .words_pending_o  (words_pending)
  );

  // pcm side: random idling, or a long hold-off when one is asked for
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      m_ready      <= 1'b0;
      hold_left    <= 0;
      holds_served <= 0;
    end else if (hold_left != 0) begin
      m_ready   <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      m_ready      <= 1'b0;
      holds_served <= holds_asked;
      hold_left    <= HOLD_CYCLES;
    end else begin
      m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // returns at the edge that took the frame
  task automatic send_frame(input logic signed [SW-1:0] left_smp,
                            input logic signed [SW-1:0] right_smp,
                            input logic eob);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {{(STW - 2 * SW){1'b0}}, right_smp, left_smp};
    s_last  <= eob;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  task automatic wait_for_drain();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_dither(input logic on);
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= on;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic signed [SW-1:0] random_sample();
    logic signed [SW-1:0] v;
    logic [31:0]          r;
    int                   off;
    r = $urandom();
    case ($urandom_range(0, 9))
      0: v = r[SW-1:0];
      1: begin
        off = $urandom_range(0, 1023);
        v   = SW'((r[31] ? 8388608 : -8388608) + off - 512);
      end
      2: v = {{2{r[15]}}, r[15:0], 8'h80};   // exact half
      default: v = {{2{r[23]}}, r[23:0]};
    endcase
    return v;
  endfunction

  initial begin
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        set_dither(1'b1);
      end
      for (int i = 0; i < NUM_CORNERS; i++) begin
        send_frame(corner_samples[i], corner_samples[NUM_CORNERS-1-i], i[0]);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      set_dither(ph % 2 == 0);
      case (ph / 2)
        0: begin
          send_idle_pct <= 36;
          recv_idle_pct <= 73;
        end
        1: begin
          send_idle_pct <= 73;
          recv_idle_pct <= 36;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      if (ph == 4) begin
        holds_asked <= holds_asked + 1;
      end
      repeat (FRAMES_PER_PASS) begin
        send_frame(random_sample(), random_sample(), $urandom_range(0, 7) == 0);
      end
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/sdq_pkg.sv
rtl/sdq_quant.sv
rtl/stereo_dither_quantizer_core.sv
tb/stereo_dither_quantizer_checker.sv
tb/stereo_dither_quantizer_core_tb.sv
